/* design/scfc_pkg.sv */
// Shared types, constants and calibration tables for the sensor calibration core.
package scfc_pkg;

    // Sensor count and derived widths
    localparam int NUM_SENSORS = 13;
    localparam int IDX_W       = 4;
    localparam int SLOT_W      = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int TEMP_W      = 12;
    localparam int CNT_W       = 8;
    localparam int COEF_A_W    = 15;
    localparam int COEF_B_W    = 7;
    localparam int PROD_W      = TEMP_W + COEF_A_W + 1;
    localparam int FRAC_W      = 14;

    // Stream word layouts
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = IDX_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = IDX_W + 2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LOWER_LIMIT = 2'd0,
        REG_UPPER_LIMIT = 2'd1,
        REG_ERROR_LIMIT = 2'd2,
        REG_FAULT_TEMP  = 2'd3
    } cfg_reg_t;

    // One entry of the per-sensor state memory
    typedef struct packed {
        logic [CNT_W-1:0]         cnt;
        logic [CNT_W-1:0]         worst;
        logic signed [TEMP_W-1:0] held;
    } scfc_entry_t;

    localparam int ENTRY_W = $bits(scfc_entry_t);

    // Result fields produced by the update stage
    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     reading_valid;
        logic                     fault;
        logic [CNT_W-1:0]         error_run;
        logic [CNT_W-1:0]         worst_error_run;
    } scfc_result_t;

    // Gain per sensor, unsigned Q1.14
    function automatic logic [COEF_A_W-1:0] coef_a(input logic [IDX_W-1:0] idx);
        logic [COEF_A_W-1:0] a;
        case (idx)
            4'd0:    a = 15'd14746;
            4'd1:    a = 15'd15319;
            4'd2:    a = 15'd14746;
            4'd3:    a = 15'd16466;
            4'd4:    a = 15'd15892;
            4'd5:    a = 15'd16220;
            4'd6:    a = 15'd15073;
            4'd7:    a = 15'd15647;
            4'd8:    a = 15'd1638;
            4'd9:    a = 15'd15892;
            4'd10:   a = 15'd15729;
            4'd11:   a = 15'd1638;
            4'd12:   a = 15'd1638;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Offset per sensor, 1/16 degC
    function automatic logic [COEF_B_W-1:0] coef_b(input logic [IDX_W-1:0] idx);
        logic [COEF_B_W-1:0] b;
        case (idx)
            4'd0:    b = 7'd123;
            4'd1:    b = 7'd75;
            4'd2:    b = 7'd99;
            4'd3:    b = 7'd56;
            4'd4:    b = 7'd56;
            4'd5:    b = 7'd56;
            4'd6:    b = 7'd80;
            4'd7:    b = 7'd43;
            4'd9:    b = 7'd26;
            4'd10:   b = 7'd35;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

/* design/scfc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module scfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and read port returning the old word on a collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/scfc_update.sv */
// Calibration finish and per-sensor error counter update for one reading.
module scfc_update (
    input  logic signed [scfc_pkg::PROD_W-1:0]   prod,
    input  logic [scfc_pkg::COEF_B_W-1:0]        coef_b,
    input  logic                                  in_range,
    input  scfc_pkg::scfc_entry_t                 old_entry,
    input  logic [scfc_pkg::CNT_W-1:0]            error_limit,
    input  logic signed [scfc_pkg::TEMP_W-1:0]    fault_temp,
    output scfc_pkg::scfc_entry_t                 new_entry,
    output scfc_pkg::scfc_result_t                result
);

    localparam int RND_W = scfc_pkg::PROD_W + 1;
    localparam int SHR_W = RND_W - scfc_pkg::FRAC_W;
    localparam int SUM_W = SHR_W + 1;

    logic signed [RND_W-1:0]            rnd;
    logic signed [SHR_W-1:0]            shr;
    logic signed [SUM_W-1:0]            sum;
    logic signed [scfc_pkg::TEMP_W-1:0] cal;
    logic [scfc_pkg::CNT_W-1:0]         cnt_inc;
    logic [scfc_pkg::CNT_W-1:0]         worst_max;
    logic                               fault;

    // Round half up, drop the fraction, add the offset, saturate
    always_comb
    begin
        rnd = RND_W'(prod) + RND_W'(1 << (scfc_pkg::FRAC_W - 1));
        shr = rnd[RND_W-1:scfc_pkg::FRAC_W];
        sum = SUM_W'(shr) + SUM_W'($signed({1'b0, coef_b}));
        if (sum > SUM_W'(2047))
        begin
            cal = 12'sd2047;
        end
        else if (sum < -SUM_W'(2048))
        begin
            cal = -12'sd2048;
        end
        else
        begin
            cal = sum[scfc_pkg::TEMP_W-1:0];
        end
    end

    // Clear or advance the error run, track the worst run and substitute the fault value past the limit
    always_comb
    begin
        cnt_inc   = (old_entry.cnt == '1) ? old_entry.cnt : old_entry.cnt + 1'b1;
        worst_max = (old_entry.worst < cnt_inc) ? cnt_inc : old_entry.worst;
        fault     = 1'b0;
        new_entry = old_entry;
        if (in_range)
        begin
            new_entry.cnt  = '0;
            new_entry.held = cal;
        end
        else
        begin
            new_entry.cnt   = cnt_inc;
            new_entry.worst = worst_max;
            if (cnt_inc > error_limit)
            begin
                fault          = 1'b1;
                new_entry.held = fault_temp;
            end
        end
        result.temperature     = new_entry.held;
        result.reading_valid   = in_range;
        result.fault           = fault;
        result.error_run       = new_entry.cnt;
        result.worst_error_run = new_entry.worst;
    end

endmodule

/* design/sensor_calibrate_and_fault_count_core.sv */
// Sensor calibration core: one reading in, one calibrated or held result out, per cycle
// while the result stream is not stalled.
// Each reading is checked against the limits, calibrated as a*raw+b (unsigned Q1.14
// gain, rounded half up, saturated to 12 bits) and its sensor's error run, worst run
// and held value are updated in a small state memory. The block takes one word per
// cycle while the result stream is not stalled; the multiply and memory read go into
// the stage register when a reading is taken, then update, write-back and the output
// register follow as the stage advances. The state memory is read and written back
// once per word; a write-back bypass covers a reading for the same sensor in the next
// cycle, so back-to-back readings of one sensor run at full rate.
// Per-sensor valid bits make the state read as zero after reset, with no clearing pass.
// Sensor numbers past the table report from a zero state and store nothing.
module sensor_calibrate_and_fault_count_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [scfc_pkg::TEMP_W-1:0]        cfg_data,
    // Reading stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [scfc_pkg::S_TDATA_W-1:0]     s_tdata,   // [11:0] raw_temp, zero pad
    input  logic [scfc_pkg::S_TUSER_W-1:0]     s_tuser,   // [3:0] sensor_index
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [scfc_pkg::M_TDATA_W-1:0]     m_tdata,   // [11:0] temperature,
                                                          // [19:12] error_run,
                                                          // [27:20] worst_error_run, pad
    output logic [scfc_pkg::M_TUSER_W-1:0]     m_tuser    // [3:0] sensor_tag,
                                                          // [4] reading_valid, [5] fault
);

    localparam int SW = scfc_pkg::SLOT_W;
    localparam int TW = scfc_pkg::TEMP_W;
    localparam int CW = scfc_pkg::CNT_W;

    // Configuration registers
    logic signed [TW-1:0] lower_limit_reg;
    logic signed [TW-1:0] upper_limit_reg;
    logic [CW-1:0]        error_limit_reg;
    logic signed [TW-1:0] fault_temp_reg;

    // Stage 1 registers
    logic                                 s1_valid_reg;
    logic [scfc_pkg::IDX_W-1:0]           s1_idx_reg;
    logic                                 s1_has_reg;
    logic                                 s1_in_range_reg;
    logic signed [scfc_pkg::PROD_W-1:0]   s1_prod_reg;

    // Write-back bypass and entry valid bits
    logic                                 fwd_valid_reg;
    logic [SW-1:0]                        fwd_slot_reg;
    scfc_pkg::scfc_entry_t                fwd_entry_reg;
    logic [scfc_pkg::NUM_SENSORS-1:0]     entry_valid_reg;

    // Output register
    logic                                 out_valid_reg;
    scfc_pkg::scfc_result_t               out_result_reg;
    logic [scfc_pkg::IDX_W-1:0]           out_tag_reg;

    logic                                 s_accept;
    logic                                 s1_advance;
    logic [scfc_pkg::IDX_W-1:0]           in_idx;
    logic                                 in_has;
    logic signed [TW-1:0]                 in_raw;
    logic                                 in_range;
    logic signed [scfc_pkg::PROD_W-1:0]   in_prod;
    logic [SW-1:0]                        s1_slot;
    logic [scfc_pkg::ENTRY_W-1:0]         ram_rd_data;
    scfc_pkg::scfc_entry_t                old_entry;
    scfc_pkg::scfc_entry_t                new_entry;
    scfc_pkg::scfc_result_t               new_result;

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    // Latch configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_limit_reg <= 12'sd80;
            upper_limit_reg <= 12'sd1280;
            error_limit_reg <= 8'd3;
            fault_temp_reg  <= 12'sd1600;
        end
        else if (cfg_valid)
        begin
            case (scfc_pkg::cfg_reg_t'(cfg_index))
                scfc_pkg::REG_LOWER_LIMIT: lower_limit_reg <= cfg_data;
                scfc_pkg::REG_UPPER_LIMIT: upper_limit_reg <= cfg_data;
                scfc_pkg::REG_ERROR_LIMIT: error_limit_reg <= cfg_data[CW-1:0];
                scfc_pkg::REG_FAULT_TEMP:  fault_temp_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 0: range check and gain multiply
    always_comb
    begin
        in_idx   = s_tuser[scfc_pkg::IDX_W-1:0];
        in_has   = (32'(in_idx) < scfc_pkg::NUM_SENSORS);
        in_raw   = in_has ? $signed(s_tdata[TW-1:0]) : '0;
        in_range = !((in_raw < lower_limit_reg) || (in_raw > upper_limit_reg));
        in_prod  = scfc_pkg::PROD_W'($signed({1'b0, scfc_pkg::coef_a(in_idx)}) * in_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_idx_reg      <= in_idx;
            s1_has_reg      <= in_has;
            s1_in_range_reg <= in_range;
            s1_prod_reg     <= in_prod;
        end
    end

    // Per-sensor state memory
    assign s1_slot = s1_idx_reg[SW-1:0];

    scfc_ram #(
        .WIDTH (scfc_pkg::ENTRY_W),
        .DEPTH (scfc_pkg::NUM_SENSORS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (s1_advance && s1_has_reg),
        .wr_addr (s1_slot),
        .wr_data (new_entry),
        .rd_en   (s_accept),
        .rd_addr (in_idx[SW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Stage 1: pick the latest copy of the entry
    always_comb
    begin
        if (!s1_has_reg)
        begin
            old_entry = '0;
        end
        else if (fwd_valid_reg && (fwd_slot_reg == s1_slot))
        begin
            old_entry = fwd_entry_reg;
        end
        else if (entry_valid_reg[s1_slot])
        begin
            old_entry = scfc_pkg::scfc_entry_t'(ram_rd_data);
        end
        else
        begin
            old_entry = '0;
        end
    end

    scfc_update u_update (
        .prod        (s1_prod_reg),
        .coef_b      (scfc_pkg::coef_b(s1_idx_reg)),
        .in_range    (s1_in_range_reg),
        .old_entry   (old_entry),
        .error_limit (error_limit_reg),
        .fault_temp  (fault_temp_reg),
        .new_entry   (new_entry),
        .result      (new_result)
    );

    // Track written entries and the last write for the bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
        end
        else if (s1_advance && s1_has_reg)
        begin
            fwd_valid_reg            <= 1'b1;
            entry_valid_reg[s1_slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_has_reg)
        begin
            fwd_slot_reg  <= s1_slot;
            fwd_entry_reg <= new_entry;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_result_reg <= new_result;
            out_tag_reg    <= s1_idx_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_result_reg.worst_error_run, out_result_reg.error_run,
                       out_result_reg.temperature};
    assign m_tuser  = {out_result_reg.fault, out_result_reg.reading_valid, out_tag_reg};

endmodule

/* design/scfc_checker.sv */
// Port-level checks for the sensor calibration core, bound to the top level.
module scfc_port_checks (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [scfc_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [scfc_pkg::M_TUSER_W-1:0]  m_tuser
);

    // Hold a result word until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word dropped or changed while stalled");

    // A valid reading clears the run and never reports a fault
    a_valid_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4] |-> m_tdata[19:12] == 8'd0 && !m_tuser[5])
        else $error("valid reading with nonzero run or fault");

    // A bad reading has a nonzero run bounded by the worst run
    a_bad_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[4] |-> m_tdata[19:12] != 8'd0 && m_tdata[27:20] >= m_tdata[19:12])
        else $error("bad reading with inconsistent run counts");

    // Sensors past the table keep no state
    a_no_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (32'(m_tuser[3:0]) >= scfc_pkg::NUM_SENSORS) && !m_tuser[4]
        |-> m_tdata[19:12] == 8'd1 && m_tdata[27:20] == 8'd1)
        else $error("stateless sensor reported accumulated run");

endmodule

bind sensor_calibrate_and_fault_count_core scfc_port_checks u_scfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
